### rtl/core/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// Shared constants, destination codes and controller/datapath structs for the
// shuffled LCG random number core.
// ----------------------------------------------------------------------------
`default_nettype none

package slr_pkg;

	// Shuffle table depth.
	localparam int TABLE_SIZE = 97;

	// Field and datapath widths.
	localparam int SEED_W      = 31;
	localparam int VALUE_W     = 20;
	localparam int N_W         = 31;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	// Generator constants.
	localparam logic [VALUE_W-1:0] LCG_MOD = 20'd714025;
	localparam logic [10:0]        LCG_MUL = 11'd1366;
	localparam logic [N_W-1:0]     LCG_INC = 31'd150889;

	// Reciprocal of the modulus, exact floor division for any N_W-bit dividend.
	localparam int RECIP_SHIFT = 51;
	localparam int RECIP_W     = 32;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(LCG_MOD) - 64'd1) / 64'(LCG_MOD));
	localparam int Q_W = N_W + RECIP_W - RECIP_SHIFT;

	// Where the result of a modular reduction is written back.
	typedef logic [2:0] dst_t;
	localparam dst_t DST_NONE  = 3'd0;
	localparam dst_t DST_START = 3'd1;
	localparam dst_t DST_FILL  = 3'd2;
	localparam dst_t DST_HELD  = 3'd3;
	localparam dst_t DST_NEXT  = 3'd4;
	localparam dst_t DST_SLOT  = 3'd5;

	typedef struct packed {
		logic issue;
		dst_t dst;
		logic fill_clr;
		logic read;
		logic commit;
		logic seed_we;
	} cmd_t;

	typedef struct packed {
		logic wb_valid;
		dst_t wb_dst;
		logic fill_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### rtl/core/shuffled_lcg_random_core.sv
// ----------------------------------------------------------------------------
// shuffled_lcg_random_core
// Random number generator: a linear congruential generator
// x' = (1366*x + 150889) mod 714025 feeding a shuffle table. Each word on the
// input stream with draw set returns one word carrying a numerator in
// [0, 714024]; a word with draw clear is accepted and returns nothing. After a
// draw the next word is not taken until the number has gone to the output
// register and the four-stage modulo unit has computed the next table slot
// from the returned number. The first draw after reset or a seed write first
// runs the set-up, with one pass through the modulo unit per table entry.
// The seed is written over the cfg channel while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module shuffled_lcg_random_core #(
	parameter int TABLE_SIZE = slr_pkg::TABLE_SIZE
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [slr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] draw
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [slr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // [19:0] value
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [slr_pkg::SEED_W-1:0]        cfg_data       // [30:0] seed
);

	slr_pkg::cmd_t                 cmd;
	slr_pkg::sts_t                 sts;
	logic [slr_pkg::VALUE_W-1:0]   value;

	slr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.draw      (s_axis_tdata[0]),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	slr_dp #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (value)
	);

	assign m_axis_tdata = {{(slr_pkg::OUT_TDATA_W - slr_pkg::VALUE_W){1'b0}}, value};

endmodule

`default_nettype wire

### rtl/core/slr_modred.sv
// ----------------------------------------------------------------------------
// slr_modred
// Four-stage pipelined reduction modulo 714025: gives quotient and remainder
// of a 31-bit dividend by a reciprocal multiply and one back-multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_modred (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [slr_pkg::N_W-1:0]     in_n,
	input  wire slr_pkg::dst_t               in_dst,
	output logic                             out_valid,
	output logic [slr_pkg::Q_W-1:0]          out_q,
	output logic [slr_pkg::VALUE_W-1:0]      out_r,
	output slr_pkg::dst_t                    out_dst
);

	localparam int PROD_W = slr_pkg::N_W + slr_pkg::RECIP_W;
	localparam int QD_W   = slr_pkg::Q_W + slr_pkg::VALUE_W;

	logic                          vld_s1, vld_s2, vld_s3, vld_s4;
	slr_pkg::dst_t                 dst_s1, dst_s2, dst_s3, dst_s4;
	logic [slr_pkg::N_W-1:0]       n_s1, n_s2, n_s3;
	logic [PROD_W-1:0]             prod_s2;
	logic [slr_pkg::Q_W-1:0]       q_s3, q_s4;
	logic [QD_W-1:0]               qd_s3;
	logic [slr_pkg::VALUE_W-1:0]   r_s4;
	logic [slr_pkg::Q_W-1:0]       q_est;
	logic [slr_pkg::N_W-1:0]       diff;

	assign q_est = prod_s2[slr_pkg::RECIP_SHIFT +: slr_pkg::Q_W];
	assign diff  = n_s3 - qd_s3[slr_pkg::N_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		n_s1    <= in_n;
		dst_s1  <= in_dst;
		prod_s2 <= PROD_W'(n_s1) * PROD_W'(slr_pkg::RECIP);
		n_s2    <= n_s1;
		dst_s2  <= dst_s1;
		// The reciprocal is exact over the whole dividend range, so the
		// remainder needs no correction step.
		q_s3    <= q_est;
		qd_s3   <= QD_W'(q_est) * QD_W'(slr_pkg::LCG_MOD);
		n_s3    <= n_s2;
		dst_s3  <= dst_s2;
		q_s4    <= q_s3;
		r_s4    <= diff[slr_pkg::VALUE_W-1:0];
		dst_s4  <= dst_s3;
	end

	assign out_valid = vld_s4;
	assign out_q     = q_s4;
	assign out_r     = r_s4;
	assign out_dst   = dst_s4;

endmodule

`default_nettype wire

### rtl/core/slr_dp.sv
// ----------------------------------------------------------------------------
// slr_dp
// Datapath: seed register, generator registers, operand forming, reduction
// unit, shuffle table memory and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_dp #(
	parameter int TABLE_SIZE = slr_pkg::TABLE_SIZE
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire slr_pkg::cmd_t                 cmd,
	output slr_pkg::sts_t                      sts,
	input  wire logic [slr_pkg::SEED_W-1:0]    cfg_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [slr_pkg::VALUE_W-1:0]        out_value
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int VW    = slr_pkg::VALUE_W;
	localparam int NW    = slr_pkg::N_W;
	localparam int QW    = slr_pkg::Q_W;

	logic [slr_pkg::SEED_W-1:0] seed_q;
	logic [VW-1:0]              gen_q;
	logic [VW-1:0]              nxt_q;
	logic [VW-1:0]              held_q;
	logic [VW-1:0]              rd_q;
	logic [IDX_W-1:0]           slot_q;
	logic [IDX_W-1:0]           fill_idx_q;
	logic                       out_valid_q;
	logic [VW-1:0]              out_value_q;

	logic [VW-1:0]              shuf_mem [TABLE_SIZE];

	logic [NW-1:0]              opnd;
	logic                       u_valid;
	logic [QW-1:0]              u_q;
	logic [VW-1:0]              u_r;
	slr_pkg::dst_t              u_dst;
	logic [QW-1:0]              q_clamped;

	logic                       mem_we;
	logic [IDX_W-1:0]           mem_wa;
	logic [VW-1:0]              mem_wd;

	always_comb begin
		case (cmd.dst)
			slr_pkg::DST_START: begin
				opnd = (seed_q > slr_pkg::LCG_INC) ? (seed_q - slr_pkg::LCG_INC)
				                                    : (slr_pkg::LCG_INC - seed_q);
			end
			slr_pkg::DST_FILL, slr_pkg::DST_HELD: begin
				opnd = NW'(slr_pkg::LCG_MUL) * NW'(gen_q) + slr_pkg::LCG_INC;
			end
			slr_pkg::DST_NEXT: begin
				opnd = NW'(slr_pkg::LCG_MUL) * NW'(nxt_q) + slr_pkg::LCG_INC;
			end
			slr_pkg::DST_SLOT: begin
				opnd = NW'(TABLE_SIZE) * NW'(held_q);
			end
			default: begin
				opnd = '0;
			end
		endcase
	end

	slr_modred u_modred (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.issue),
		.in_n      (opnd),
		.in_dst    (cmd.dst),
		.out_valid (u_valid),
		.out_q     (u_q),
		.out_r     (u_r),
		.out_dst   (u_dst)
	);

	assign q_clamped = (u_q > QW'(TABLE_SIZE - 1)) ? QW'(TABLE_SIZE - 1) : u_q;

	// A draw writes the precomputed next generator value into the slot it reads.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot_q;
		mem_wd = nxt_q;
		if (cmd.read) begin
			mem_we = 1'b1;
		end else if (u_valid && (u_dst == slr_pkg::DST_FILL)) begin
			mem_we = 1'b1;
			mem_wa = fill_idx_q;
			mem_wd = u_r;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			shuf_mem[mem_wa] <= mem_wd;
		end
		if (cmd.read) begin
			rd_q <= shuf_mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= slr_pkg::SEED_W'(1);
			fill_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.seed_we) begin
				seed_q <= cfg_data;
			end
			if (cmd.fill_clr) begin
				fill_idx_q <= '0;
			end else if (u_valid && (u_dst == slr_pkg::DST_FILL)) begin
				fill_idx_q <= fill_idx_q + IDX_W'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (u_valid) begin
			case (u_dst)
				slr_pkg::DST_START, slr_pkg::DST_FILL: begin
					gen_q <= u_r;
				end
				slr_pkg::DST_HELD: begin
					held_q <= u_r;
					nxt_q  <= u_r;
				end
				slr_pkg::DST_NEXT: begin
					nxt_q <= u_r;
				end
				slr_pkg::DST_SLOT: begin
					slot_q <= q_clamped[IDX_W-1:0];
				end
				default: begin
				end
			endcase
		end
		if (cmd.commit) begin
			out_value_q <= rd_q;
			held_q      <= rd_q;
		end
	end

	assign sts.wb_valid  = u_valid;
	assign sts.wb_dst    = u_dst;
	assign sts.fill_last = (fill_idx_q == IDX_W'(TABLE_SIZE - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;

endmodule

`default_nettype wire

### rtl/core/slr_ctrl.sv
// ----------------------------------------------------------------------------
// slr_ctrl
// Controller: input and configuration handshakes, set-up sequencing and the
// per-draw read, commit and slot recompute steps.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           draw,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	output slr_pkg::cmd_t       cmd,
	input  wire slr_pkg::sts_t  sts
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_START  = 4'd1;
	localparam logic [3:0] S_WSTART = 4'd2;
	localparam logic [3:0] S_FILL   = 4'd3;
	localparam logic [3:0] S_WFILL  = 4'd4;
	localparam logic [3:0] S_HOLD   = 4'd5;
	localparam logic [3:0] S_WHOLD  = 4'd6;
	localparam logic [3:0] S_PNEXT  = 4'd7;
	localparam logic [3:0] S_PSLOT  = 4'd8;
	localparam logic [3:0] S_WSLOT  = 4'd9;
	localparam logic [3:0] S_READ   = 4'd10;
	localparam logic [3:0] S_COMMIT = 4'd11;

	logic [3:0] state_q, state_d;
	logic       init_q, init_d;
	logic       pend_q, pend_d;
	logic       in_acc;
	logic       cfg_acc;

	// Configuration takes priority over a draw offered in the same cycle.
	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_comb begin
		state_d      = state_q;
		init_d       = init_q;
		pend_d       = pend_q;
		cmd          = '0;
		cmd.dst      = slr_pkg::DST_NONE;
		cmd.seed_we  = cfg_acc;
		if (cfg_acc) begin
			init_d = 1'b0;
		end
		case (state_q)
			S_IDLE: begin
				if (in_acc && draw) begin
					if (init_q) begin
						state_d = S_READ;
					end else begin
						state_d = S_START;
						pend_d  = 1'b1;
					end
				end
			end
			S_START: begin
				cmd.issue    = 1'b1;
				cmd.dst      = slr_pkg::DST_START;
				cmd.fill_clr = 1'b1;
				state_d      = S_WSTART;
			end
			S_WSTART: begin
				if (sts.wb_valid) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				cmd.issue = 1'b1;
				cmd.dst   = slr_pkg::DST_FILL;
				state_d   = S_WFILL;
			end
			S_WFILL: begin
				if (sts.wb_valid) begin
					state_d = sts.fill_last ? S_HOLD : S_FILL;
				end
			end
			S_HOLD: begin
				cmd.issue = 1'b1;
				cmd.dst   = slr_pkg::DST_HELD;
				state_d   = S_WHOLD;
			end
			S_WHOLD: begin
				if (sts.wb_valid) begin
					state_d = S_PNEXT;
				end
			end
			S_PNEXT: begin
				cmd.issue = 1'b1;
				cmd.dst   = slr_pkg::DST_NEXT;
				state_d   = S_PSLOT;
			end
			S_PSLOT: begin
				cmd.issue = 1'b1;
				cmd.dst   = slr_pkg::DST_SLOT;
				state_d   = S_WSLOT;
			end
			S_WSLOT: begin
				// The slot result is always the last one in flight.
				if (sts.wb_valid && (sts.wb_dst == slr_pkg::DST_SLOT)) begin
					init_d  = 1'b1;
					pend_d  = 1'b0;
					state_d = pend_q ? S_READ : S_IDLE;
				end
			end
			S_READ: begin
				cmd.read  = 1'b1;
				cmd.issue = 1'b1;
				cmd.dst   = slr_pkg::DST_NEXT;
				state_d   = S_COMMIT;
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_PSLOT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			init_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			init_q  <= init_d;
			pend_q  <= pend_d;
		end
	end

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !sts.wb_valid)
		else $error("reduction result arrived while idle");

	a_fill_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WFILL && sts.wb_valid && !sts.fill_last) |=> (state_q == S_FILL))
		else $error("table fill stopped early");

	a_seed_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> !init_q)
		else $error("seed write did not force set-up");

	a_read_init: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |-> init_q)
		else $error("table read before set-up finished");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for shuffled_lcg_random_core. Draw and no-draw words are
// streamed in, and the seed is rewritten between runs. A bit-accurate model of
// the generator and its shuffle table predicts every returned number. The
// returned words are checked in order, mostly with random idle on both sides.
// ----------------------------------------------------------------------------

module tb;

	import slr_pkg::*;

	localparam longint unsigned GEN_MOD = 714025;
	localparam longint unsigned GEN_MUL = 1366;
	localparam longint unsigned GEN_INC = 150889;
	localparam int QUIET_CYCLES = 40;
	localparam int PHASE_DRAWS  = 410;
	localparam longint CYCLE_LIMIT = 2000000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [SEED_W-1:0]      cfg_data = '0;

	// Model of the generator.
	logic [SEED_W-1:0]  seed_reg = 31'd1;
	logic [VALUE_W-1:0] gen_state = '0;
	logic [VALUE_W-1:0] shuffle_tbl [TABLE_SIZE];
	logic [VALUE_W-1:0] held_num = '0;
	logic               tbl_ready = 1'b0;

	logic [VALUE_W-1:0] pending_values [$];
	int     mismatches = 0;
	int     src_idle_pct = 0;
	int     sink_idle_pct = 0;
	longint cycle_count = 0;

	shuffled_lcg_random_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [0] draw
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [19:0] value
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)        // [30:0] seed
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	function automatic logic [VALUE_W-1:0] lcg_advance(logic [VALUE_W-1:0] x);
		longint unsigned t;
		t = (GEN_MUL * (longint'(x) % GEN_MOD) + GEN_INC) % GEN_MOD;
		return t[VALUE_W-1:0];
	endfunction

	// Advances the model by one draw and returns the number it yields.
	function automatic logic [VALUE_W-1:0] next_random();
		longint unsigned sd;
		longint unsigned span;
		longint unsigned slot;
		logic [VALUE_W-1:0] picked;
		int k;
		if (!tbl_ready) begin
			sd = seed_reg;
			if (sd > GEN_INC)
				span = sd - GEN_INC;
			else
				span = GEN_INC - sd;
			gen_state = VALUE_W'(span % GEN_MOD);
			for (k = 0; k < TABLE_SIZE; k++) begin
				gen_state = lcg_advance(gen_state);
				shuffle_tbl[k] = gen_state;
			end
			gen_state = lcg_advance(gen_state);
			held_num = gen_state;
			tbl_ready = 1'b1;
		end
		slot = (longint'(TABLE_SIZE) * longint'(held_num)) / GEN_MOD;
		if (slot >= TABLE_SIZE)
			slot = TABLE_SIZE - 1;
		picked = shuffle_tbl[slot];
		gen_state = lcg_advance(gen_state);
		shuffle_tbl[slot] = gen_state;
		held_num = picked;
		return picked;
	endfunction

	task automatic note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin
		logic [VALUE_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_values.size() == 0) begin
				note_mismatch($sformatf("unexpected word: value %0d", m_axis_tdata[VALUE_W-1:0]));
			end else begin
				want = pending_values.pop_front();
				if (m_axis_tdata[VALUE_W-1:0] !== want)
					note_mismatch($sformatf("value mismatch: expected %0d, got %0d",
						want, m_axis_tdata[VALUE_W-1:0]));
			end
		end
	end

	// Entered at a falling edge; returns at the falling edge after acceptance.
	// The valid line is left high so a following word can go out back to back.
	task automatic send_word(input bit draw_bit);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, draw_bit};
		do @(posedge clk); while (!s_axis_tready);
		if (draw_bit)
			pending_values.push_back(next_random());
		@(negedge clk);
	endtask

	// Stops the stream and waits for every outstanding number plus a quiet spell.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_values.size() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [SEED_W-1:0] new_seed);
		cfg_valid <= 1'b1;
		cfg_data  <= new_seed;
		do @(posedge clk); while (!cfg_ready);
		seed_reg  = new_seed;
		tbl_ready = 1'b0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// The reset seed is used without any write; a no-draw word must not start set-up.
	task automatic test_reset_seed();
		send_word(1'b0);
		send_word(1'b1);
		send_word(1'b1);
		send_word(1'b1);
		drain();
	endtask

	task automatic test_seed_extremes();
		logic [SEED_W-1:0] seeds [6];
		int i;
		seeds[0] = '0;
		seeds[1] = 31'd150889;               // start value of zero
		seeds[2] = 31'd150888;
		seeds[3] = 31'd150890;
		seeds[4] = 31'd864914;               // increment plus one modulus
		seeds[5] = 31'h7fff_ffff;
		for (i = 0; i < 6; i++) begin
			write_seed(seeds[i]);
			send_word(1'b0);
			send_word(1'b1);
			send_word(1'b1);
			drain();
		end
	endtask

	task automatic test_random_runs();
		int phase;
		int draws;
		int seg_left;
		bit draw_bit;
		logic [SEED_W-1:0] pick;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin src_idle_pct = 23; sink_idle_pct = 58; end
				1: begin src_idle_pct = 58; sink_idle_pct = 23; end
				default: begin src_idle_pct = 0; sink_idle_pct = 0; end
			endcase
			draws = 0;
			while (draws < PHASE_DRAWS) begin
				if ($urandom_range(3) != 0) begin
					case ($urandom_range(2))
						0: pick = SEED_W'($urandom);
						1: pick = SEED_W'($urandom_range(300000));
						default: pick = SEED_W'($urandom_range(2000000));
					endcase
					write_seed(pick);
				end
				seg_left = $urandom_range(160, 40);
				while (seg_left > 0) begin
					draw_bit = ($urandom_range(99) < 85);
					send_word(draw_bit);
					if (draw_bit) begin
						draws++;
						seg_left--;
					end
				end
				drain();
			end
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		src_idle_pct  = 23;
		sink_idle_pct = 58;
		test_reset_seed();
		test_seed_extremes();
		test_random_runs();
		drain();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
